@@ rtl/sslu_pkg.sv @@
// ----------------------------------------------------------------------------
// sslu_pkg
// Shared sizes and codes for the sorted linked list unit.
// ----------------------------------------------------------------------------
package sslu_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int LNK_W = $clog2(SLOTS + 1);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int VAL_W = 32;

	// end-of-chain marker: one past the last slot
	localparam logic [LNK_W-1:0] END_MARK = LNK_W'(SLOTS);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

endpackage

@@ rtl/sslu_ram.sv @@
// ----------------------------------------------------------------------------
// sslu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sslu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/sorted_static_linked_list_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_static_linked_list_unit
// Ascending list of signed words in a fixed slot array, with a free chain.
// ----------------------------------------------------------------------------
// Steps: insert S_FREE, S_WALK, S_FIX; remove hit S_WALK, S_FIX; remove miss
// S_WALK only. The walk passes at most SLOTS elements; full insert: from S_IDLE.
// One chain step per cycle through the shared read port of the value/link RAMs.
// busy stays high for the whole operation, a full insert apart; done comes with busy low.
// Reset: list empty, every slot on the free chain; link RAM reads its reset
// value through per-slot valid bits, so no clearing pass is needed.
module sorted_static_linked_list_unit
	import sslu_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    kind,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic [1:0]              status,
	output logic [IDX_W-1:0]        slot,
	output logic [CNT_W-1:0]        count
);

	typedef enum logic [2:0] {S_IDLE, S_FREE, S_WALK, S_FIX} state_t;

	state_t                  state_q;
	logic                    kind_q;
	logic signed [VAL_W-1:0] value_q;
	logic [LNK_W-1:0]        head_q, free_head_q, free_nxt_q;
	logic [LNK_W-1:0]        prev_q, cur_q, tgt_q, steps_q;
	logic [IDX_W-1:0]        s_q;
	logic [CNT_W-1:0]        count_q;
	logic                    done_q;
	logic [1:0]              status_q;
	logic [IDX_W-1:0]        slot_q;

	logic [SLOTS-1:0]        link_vld_q;
	logic                    rvld_q;
	logic [IDX_W-1:0]        ridx_q;

	logic [IDX_W-1:0]        rd_addr;
	logic signed [VAL_W-1:0] rd_val;
	logic [LNK_W-1:0]        ram_link, rd_link, nxt_link;
	logic                    lw_en, vw_en;
	logic [IDX_W-1:0]        lw_addr;
	logic [LNK_W-1:0]        lw_data;
	logic                    walk_cont, hit;

	sslu_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
		.clk   (clk),
		.we    (vw_en),
		.waddr (s_q),
		.wdata (value_q),
		.raddr (rd_addr),
		.rdata (rd_val)
	);

	sslu_ram #(.WIDTH(LNK_W), .DEPTH(SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (lw_en),
		.waddr (lw_addr),
		.wdata (lw_data),
		.raddr (rd_addr),
		.rdata (ram_link)
	);

	// never-written link reads as its reset value: next slot in order
	assign rd_link  = rvld_q ? ram_link : (LNK_W'(ridx_q) + LNK_W'(1));
	assign nxt_link = (rd_link < END_MARK) ? rd_link : END_MARK;

	assign walk_cont = (cur_q != END_MARK) && (steps_q < END_MARK) && (rd_val < value_q);
	assign hit       = (cur_q != END_MARK) && (rd_val == value_q);

	always_comb begin
		rd_addr = '0;
		lw_en   = 1'b0;
		vw_en   = 1'b0;
		lw_addr = '0;
		lw_data = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = (kind == KIND_INSERT) ? free_head_q[IDX_W-1:0] : head_q[IDX_W-1:0];
			end
			S_FREE: begin
				rd_addr = head_q[IDX_W-1:0];
			end
			S_WALK: begin
				// next read follows the link just fetched
				rd_addr = nxt_link[IDX_W-1:0];
				if (!walk_cont) begin
					if (kind_q == KIND_INSERT) begin
						vw_en   = 1'b1;
						lw_en   = 1'b1;
						lw_addr = s_q;
						lw_data = cur_q;
					end else if (hit) begin
						lw_en   = 1'b1;
						lw_addr = cur_q[IDX_W-1:0];
						lw_data = free_head_q;
					end
				end
			end
			S_FIX: begin
				if (prev_q != END_MARK) begin
					lw_en   = 1'b1;
					lw_addr = prev_q[IDX_W-1:0];
					lw_data = tgt_q;
				end
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;
	assign count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= END_MARK;
			free_head_q <= '0;
			count_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_DONE;
			slot_q      <= '0;
			link_vld_q  <= '0;
			rvld_q      <= 1'b0;
			ridx_q      <= '0;
		end else begin
			rvld_q <= link_vld_q[rd_addr];
			ridx_q <= rd_addr;
			if (lw_en) begin
				link_vld_q[lw_addr] <= 1'b1;
			end
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						value_q <= value;
						prev_q  <= END_MARK;
						cur_q   <= head_q;
						steps_q <= '0;
						s_q     <= free_head_q[IDX_W-1:0];
						if (kind == KIND_INSERT) begin
							if (free_head_q == END_MARK) begin
								done_q   <= 1'b1;
								status_q <= ST_FULL;
								slot_q   <= '0;
							end else begin
								state_q <= S_FREE;
							end
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_FREE: begin
					free_nxt_q <= nxt_link;
					state_q    <= S_WALK;
				end
				S_WALK: begin
					if (walk_cont) begin
						prev_q  <= cur_q;
						cur_q   <= nxt_link;
						steps_q <= steps_q + LNK_W'(1);
					end else if (kind_q == KIND_INSERT) begin
						tgt_q   <= LNK_W'(s_q);
						state_q <= S_FIX;
					end else if (hit) begin
						tgt_q   <= nxt_link;
						state_q <= S_FIX;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_NOTFOUND;
						slot_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_FIX: begin
					if (prev_q == END_MARK) begin
						head_q <= tgt_q;
					end
					if (kind_q == KIND_INSERT) begin
						free_head_q <= free_nxt_q;
						count_q     <= count_q + CNT_W'(1);
						slot_q      <= s_q;
					end else begin
						free_head_q <= cur_q;
						if (count_q != '0) begin
							count_q <= count_q - CNT_W'(1);
						end
						slot_q <= cur_q[IDX_W-1:0];
					end
					done_q   <= 1'b1;
					status_q <= ST_DONE;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/sslu_checker.sv @@
// ----------------------------------------------------------------------------
// sslu_checker
// Port-level checks on the sorted linked list unit, bound to the top level.
// ----------------------------------------------------------------------------
module sslu_checker
	import sslu_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic [IDX_W-1:0] slot,
	input logic [CNT_W-1:0] count
);

	// a word is only delivered once the unit has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// the element count only moves together with a delivered word
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count) |-> done)
		else $error("count changed without done");

	// failed operations leave the list alone and report slot zero
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL || status == ST_NOTFOUND) |-> slot == '0 && $stable(count))
		else $error("failed operation changed state");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> count == CNT_W'(SLOTS))
		else $error("full reported below capacity");

	// an accepted item that is not an instant full reply keeps the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item lost");

endmodule

bind sorted_static_linked_list_unit sslu_checker u_sslu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.slot   (slot),
	.count  (count)
);

@@ tb/sorted_static_linked_list_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_static_linked_list_unit_tb
// Drives insert and remove words into the sorted list unit and predicts every
// reply from a local copy of the slot array, link array and free chain.
// Directed tests cover the empty list, value extremes, equal values and a full
// list. Random traffic in fill, drain and balanced phases follows.
// ----------------------------------------------------------------------------
module sorted_static_linked_list_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sslu_pkg::*;

	localparam int RANDOM_WORDS    = 1900;
	localparam int MAX_GAP         = 17;
	localparam int SETTLE_CYCLES   = 30;
	localparam int WATCHDOG_CYCLES = 2000;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] count;
	} list_reply_t;

	logic                    clk    = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start  = 1'b0;
	logic                    kind   = KIND_INSERT;
	logic signed [VAL_W-1:0] value  = '0;
	logic                    busy;
	logic                    done;
	logic [1:0]              status;
	logic [IDX_W-1:0]        slot;
	logic [CNT_W-1:0]        count;

	// local copy of the list
	logic signed [VAL_W-1:0] list_val [SLOTS];
	logic [LNK_W-1:0]        list_link[SLOTS];
	logic [LNK_W-1:0]        list_head;
	logic [LNK_W-1:0]        free_head;
	logic [CNT_W-1:0]        list_count;

	list_reply_t expected_replies[$];
	int          mismatches   = 0;
	int          quiet_cycles = 0;
	bit          no_gaps      = 1'b0;

	sorted_static_linked_list_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.kind   (kind),
		.value  (value),
		.done   (done),
		.status (status),
		.slot   (slot),
		.count  (count)
	);

	always #1 clk = ~clk;

	function automatic void clear_list();
		for (int i = 0; i < SLOTS; i++) begin
			list_val[i]  = '0;
			list_link[i] = LNK_W'(i + 1);
		end
		list_head  = END_MARK;
		free_head  = '0;
		list_count = '0;
	endfunction

	// walk while the element is below v; prev is END_MARK when stopping at head
	function automatic void find_stop(input logic signed [VAL_W-1:0] v,
			output logic [LNK_W-1:0] prev, output logic [LNK_W-1:0] cur);
		int steps;
		steps = 0;
		prev  = END_MARK;
		cur   = list_head;
		while (cur < END_MARK && steps < SLOTS && list_val[cur[IDX_W-1:0]] < v) begin
			prev = cur;
			cur  = list_link[cur[IDX_W-1:0]];
			steps++;
		end
	endfunction

	function automatic list_reply_t apply_op(input logic k,
			input logic signed [VAL_W-1:0] v);
		list_reply_t      r;
		logic [LNK_W-1:0] prev;
		logic [LNK_W-1:0] cur;
		logic [LNK_W-1:0] s;
		r = '0;
		if (k == KIND_INSERT) begin
			if (free_head >= END_MARK) begin
				r.status = ST_FULL;
			end else begin
				s = free_head;
				free_head = list_link[s[IDX_W-1:0]];
				list_val[s[IDX_W-1:0]] = v;
				find_stop(v, prev, cur);
				list_link[s[IDX_W-1:0]] = cur;
				if (prev >= END_MARK)
					list_head = s;
				else
					list_link[prev[IDX_W-1:0]] = s;
				list_count++;
				r.status = ST_DONE;
				r.slot   = s[IDX_W-1:0];
			end
		end else begin
			find_stop(v, prev, cur);
			if (cur < END_MARK && list_val[cur[IDX_W-1:0]] == v) begin
				if (prev >= END_MARK)
					list_head = list_link[cur[IDX_W-1:0]];
				else
					list_link[prev[IDX_W-1:0]] = list_link[cur[IDX_W-1:0]];
				list_link[cur[IDX_W-1:0]] = free_head;
				free_head = cur;
				list_count--;
				r.status = ST_DONE;
				r.slot   = cur[IDX_W-1:0];
			end else begin
				r.status = ST_NOTFOUND;
			end
		end
		r.count = list_count;
		return r;
	endfunction

	// half the values small so that duplicates and hits are common
	function automatic logic signed [VAL_W-1:0] random_value();
		int near;
		near = $urandom_range(0, 16);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return near - 8;
			4, 5, 6:    return $urandom;
			7:          return 32'h7FFF_FFFF - $urandom_range(0, 3);
			8:          return 32'h8000_0000 + $urandom_range(0, 3);
			default:    return $urandom & 32'hFF;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] listed_value();
		logic [LNK_W-1:0] cur;
		int               hops;
		if (list_count == 0)
			return random_value();
		hops = $urandom_range(0, list_count - 1);
		cur  = list_head;
		for (int i = 0; i < hops; i++)
			cur = list_link[cur[IDX_W-1:0]];
		return list_val[cur[IDX_W-1:0]];
	endfunction

	task automatic send_word(input logic k, input logic signed [VAL_W-1:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		expected_replies.push_back(apply_op(k, v));
	endtask

	task automatic pause_until_quiet();
		start <= 1'b0;
		do @(posedge clk); while (expected_replies.size() != 0);
	endtask

	task automatic test_remove_from_empty();
		send_word(KIND_REMOVE, 32'sd0);
	endtask

	task automatic test_extremes_and_duplicates();
		send_word(KIND_INSERT, 32'sh7FFF_FFFF);
		send_word(KIND_INSERT, 32'sh8000_0000);
		send_word(KIND_INSERT, -32'sd1);
		send_word(KIND_INSERT, 32'sd0);
		send_word(KIND_INSERT, 32'sd0);
		send_word(KIND_REMOVE, 32'sh8000_0000);  // head
		send_word(KIND_REMOVE, 32'sh7FFF_FFFF);  // tail
		send_word(KIND_REMOVE, 32'sd0);          // first of two equal
		send_word(KIND_REMOVE, 32'sd7);          // absent
	endtask

	task automatic test_fill_to_full();
		while (list_count < SLOTS)
			send_word(KIND_INSERT, random_value());
		send_word(KIND_INSERT, 32'sd5);
		pause_until_quiet();
	endtask

	task automatic test_random_mix();
		int phase;
		int insert_pct;
		logic op;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			phase   = (i / 120) % 4;
			no_gaps = (phase == 3);
			case (phase)
				0:       insert_pct = 75;
				1:       insert_pct = 25;
				default: insert_pct = 50;
			endcase
			op = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
			if (op == KIND_INSERT)
				send_word(op, random_value());
			else
				send_word(op, ($urandom_range(0, 9) < 7) ? listed_value() : random_value());
			if (i % 250 == 249)
				pause_until_quiet();
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin : check_replies
		list_reply_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				$display("%0t: reply with no word pending: status %0d slot %0d count %0d",
					$time, status, slot, count);
			end else begin
				want = expected_replies.pop_front();
				if (status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, status);
				end
				if (slot !== want.slot) begin
					mismatches++;
					$display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
				end
				if (count !== want.count) begin
					mismatches++;
					$display("%0t: count expected %0d actual %0d",
						$time, want.count, count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_CYCLES)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		clear_list();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_remove_from_empty();
		test_extremes_and_duplicates();
		test_fill_to_full();
		test_random_mix();

		pause_until_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sslu_pkg.sv
rtl/sslu_ram.sv
rtl/sorted_static_linked_list_unit.sv
rtl/sslu_checker.sv
tb/sorted_static_linked_list_unit_tb.sv
